/* design/lbrs_pkg.sv */
// ----------------------------------------------------------------------------
// lbrs_pkg
// shared constants and controller/datapath command and status types for the
// bucketed reservoir sampler
// ----------------------------------------------------------------------------
package lbrs_pkg;

  // field widths of the item and result
  localparam int ActW    = 1;
  localparam int TblW    = 2;
  localparam int BktW    = 10;
  localparam int IdW     = 32;
  localparam int RndW    = 31;
  localparam int SlotW   = 5;
  localparam int CntW    = 32;
  localparam int MaxOut  = 32;

  // contents reported for a slot that holds no id
  localparam logic [IdW-1:0] EMPTY_WORD = 32'h7FFF_FFFF;

  // action codes
  localparam logic [ActW-1:0] ACT_INSERT = 1'b0;
  localparam logic [ActW-1:0] ACT_QUERY  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clr_en;        // zero one count entry of the clearing pass
    logic capture;       // latch an accepted item
    logic cnt_rd;        // read the bucket count
    logic ins_fill;      // reservoir not full: store at slot count
    logic ins_bad;       // table out of range: not stored
    logic cnt_bump;      // reservoir full: bump count, start remainder
    logic ins_div_done;  // remainder ready: store if inside the reservoir
    logic q_step;        // read and emit one query slot
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic tbl_valid;
    logic cnt_below;
    logic div_done;
    logic q_last;
  } sts_t;

endpackage

/* design/lbrs_div.sv */
// ----------------------------------------------------------------------------
// lbrs_div
// restoring remainder unit: random word mod (count + 1), one bit per cycle
// ----------------------------------------------------------------------------
module lbrs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lbrs_pkg::RndW-1:0]  dividend_i,
  input  logic [lbrs_pkg::CntW:0]    divisor_i,
  output logic                       done_o,
  output logic [lbrs_pkg::CntW-1:0]  rem_o
);
  import lbrs_pkg::*;

  localparam int StepW = $clog2(RndW);

  logic             run_q;
  logic             done_q;
  logic [StepW-1:0] step_q;
  logic [RndW-1:0]  dvd_q;
  logic [CntW:0]    dvs_q;
  logic [CntW-1:0]  rem_q;
  logic [CntW:0]    trial;
  logic [CntW:0]    diff;
  logic [CntW-1:0]  rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[RndW-1]};
    diff  = trial - dvs_q;
    // remainder stays below the divisor, which is at most 2^32
    rem_d = (trial >= dvs_q) ? diff[CntW-1:0] : trial[CntW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(RndW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[RndW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* design/lbrs_dp.sv */
// ----------------------------------------------------------------------------
// lbrs_dp
// datapath: count and reservoir memories, item registers, remainder unit and
// result registers
// ----------------------------------------------------------------------------
module lbrs_dp #(
  parameter int TABLES      = 4,
  parameter int BUCKET_BITS = 10,
  parameter int RES_SIZE    = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lbrs_pkg::cmd_t              cmd_i,
  output lbrs_pkg::sts_t              sts_o,
  input  logic [lbrs_pkg::ActW-1:0]   action_i,
  input  logic [lbrs_pkg::TblW-1:0]   table_req_i,
  input  logic [lbrs_pkg::BktW-1:0]   bucket_i,
  input  logic [lbrs_pkg::IdW-1:0]    vector_id_i,
  input  logic [lbrs_pkg::RndW-1:0]   random_word_i,
  output logic                        strobe_o,
  output logic [lbrs_pkg::SlotW-1:0]  slot_o,
  output logic [lbrs_pkg::IdW-1:0]    value_o,
  output logic                        stored_o,
  output logic                        bucket_empty_o,
  output logic                        last_o
);
  import lbrs_pkg::*;

  localparam int TW     = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int CAW    = TW + BUCKET_BITS;
  localparam int SW     = (RES_SIZE > 1) ? $clog2(RES_SIZE) : 1;
  localparam int CDEPTH = 1 << CAW;
  localparam int RDEPTH = 1 << (CAW + SW);
  localparam int NQ     = (RES_SIZE < MaxOut) ? RES_SIZE : MaxOut;
  localparam int KW     = (NQ > 1) ? $clog2(NQ) : 1;

  logic [CntW-1:0] cnt_mem [CDEPTH];
  logic [IdW-1:0]  res_mem [RDEPTH];

  // item registers
  logic            query_q;
  logic            tvld_q;
  logic [CAW-1:0]  idx_q;
  logic [IdW-1:0]  vid_q;
  logic [RndW-1:0] rnd_q;

  logic [CAW-1:0]  clr_q;
  logic [CntW-1:0] cnt_rd_q;
  logic [IdW-1:0]  res_rd_q;
  logic [KW-1:0]   k_q;

  // result registers
  logic             out_vld_q;
  logic [SlotW-1:0] out_slot_q;
  logic [IdW-1:0]   out_val_q;
  logic             out_mem_q;
  logic             out_stored_q;
  logic             out_empty_q;
  logic             out_last_q;

  logic [7:0]       tbl_ext;
  logic [19:0]      bkt_ext;
  logic             tvld_d;
  logic [CAW-1:0]   idx_d;
  logic [CntW-1:0]  cnt_inc;
  logic             cnt_we;
  logic [CAW-1:0]   cnt_wa;
  logic [CntW-1:0]  cnt_wd;
  logic             div_done;
  logic [CntW-1:0]  div_rem;
  logic             rem_in;
  logic             res_we;
  logic [SW-1:0]    res_wslot;
  logic             q_last;

  always_comb begin
    tbl_ext = 8'(table_req_i);
    bkt_ext = 20'(bucket_i);
    tvld_d  = (32'(table_req_i) < TABLES);
    idx_d   = tvld_d ? {tbl_ext[TW-1:0], bkt_ext[BUCKET_BITS-1:0]} : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      query_q <= (action_i == ACT_QUERY);
      tvld_q  <= tvld_d;
      idx_q   <= idx_d;
      vid_q   <= vector_id_i;
      rnd_q   <= random_word_i;
    end
  end

  // count memory: clearing pass, fill and saturating bump share one write port
  always_comb begin
    cnt_inc = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + 32'd1;
    cnt_we  = cmd_i.clr_en | cmd_i.ins_fill | cmd_i.cnt_bump;
    cnt_wa  = cmd_i.clr_en ? clr_q : idx_q;
    cnt_wd  = cmd_i.clr_en ? '0 : cnt_inc;
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd_i.cnt_rd) begin
      cnt_rd_q <= cnt_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      k_q   <= '0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + CAW'(1);
      end
      if (cmd_i.capture) begin
        k_q <= '0;
      end else if (cmd_i.q_step) begin
        k_q <= k_q + KW'(1);
      end
    end
  end

  lbrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.cnt_bump),
    .dividend_i (rnd_q),
    .divisor_i  ({1'b0, cnt_rd_q} + 33'd1),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // reservoir memory
  always_comb begin
    rem_in    = (div_rem < 32'(RES_SIZE));
    res_we    = cmd_i.ins_fill | (cmd_i.ins_div_done & rem_in);
    res_wslot = cmd_i.ins_fill ? cnt_rd_q[SW-1:0] : div_rem[SW-1:0];
    q_last    = (k_q == KW'(NQ - 1));
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_mem[{idx_q, res_wslot}] <= vid_q;
    end
    if (cmd_i.q_step) begin
      res_rd_q <= res_mem[{idx_q, SW'(k_q)}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= cmd_i.q_step | cmd_i.ins_fill | cmd_i.ins_div_done | cmd_i.ins_bad;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_step) begin
      out_slot_q   <= 5'(k_q);
      out_val_q    <= EMPTY_WORD;
      // slots below the count have been written since reset
      out_mem_q    <= tvld_q && (32'(k_q) < cnt_rd_q);
      out_stored_q <= 1'b0;
      out_empty_q  <= !tvld_q || (cnt_rd_q == '0);
      out_last_q   <= q_last;
    end else if (cmd_i.ins_fill) begin
      out_slot_q   <= 5'(cnt_rd_q);
      out_val_q    <= vid_q;
      out_mem_q    <= 1'b0;
      out_stored_q <= 1'b1;
      out_empty_q  <= 1'b0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.ins_div_done) begin
      out_slot_q   <= rem_in ? 5'(div_rem) : '0;
      out_val_q    <= rem_in ? vid_q : '0;
      out_mem_q    <= 1'b0;
      out_stored_q <= rem_in;
      out_empty_q  <= 1'b0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.ins_bad) begin
      out_slot_q   <= '0;
      out_val_q    <= '0;
      out_mem_q    <= 1'b0;
      out_stored_q <= 1'b0;
      out_empty_q  <= 1'b0;
      out_last_q   <= 1'b1;
    end
  end

  always_comb begin
    sts_o.clr_last  = (clr_q == CAW'(CDEPTH - 1));
    sts_o.is_query  = query_q;
    sts_o.tbl_valid = tvld_q;
    sts_o.cnt_below = (cnt_rd_q < 32'(RES_SIZE));
    sts_o.div_done  = div_done;
    sts_o.q_last    = q_last;
  end

  assign strobe_o       = out_vld_q;
  assign slot_o         = out_slot_q;
  assign value_o        = out_mem_q ? res_rd_q : out_val_q;
  assign stored_o       = out_stored_q;
  assign bucket_empty_o = out_empty_q;
  assign last_o         = out_last_q;

endmodule

/* design/lbrs_ctrl.sv */
// ----------------------------------------------------------------------------
// lbrs_ctrl
// controller: clearing pass, item sequencing and query slot walk
// ----------------------------------------------------------------------------
module lbrs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  lbrs_pkg::sts_t  sts_i,
  output lbrs_pkg::cmd_t  cmd_o
);
  import lbrs_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RDCNT = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_QRUN  = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_RDCNT;
        end
      end
      S_RDCNT: begin
        cmd_o.cnt_rd = 1'b1;
        state_d      = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.is_query) begin
          state_d = S_QRUN;
        end else if (!sts_i.tbl_valid) begin
          cmd_o.ins_bad = 1'b1;
          state_d       = S_IDLE;
        end else if (sts_i.cnt_below) begin
          cmd_o.ins_fill = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.cnt_bump = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.ins_div_done = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_QRUN: begin
        cmd_o.q_step = 1'b1;
        if (sts_i.q_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* design/lsh_bucket_reservoir_sampler.sv */
// ----------------------------------------------------------------------------
// lsh_bucket_reservoir_sampler
// per-bucket reservoir sampler over a set of hash tables
// ----------------------------------------------------------------------------
// Timing for a user: after reset the block runs a clearing pass over all
// TABLES*2^BUCKET_BITS count memory entries (4096 by default, table count
// rounded up to a power of two), with busy_o high. An item is taken when
// start_i is high and busy_o is low. An insert into a bucket whose reservoir
// is not yet full, or into a table out of range, keeps busy_o high through
// the count read and evaluation; its one result shows as busy_o falls. An
// insert into a full reservoir runs the remainder random_word mod (count+1)
// through a bit-serial unit, one bit a cycle, and keeps busy_o high until the
// remainder is done. A query walks the reservoir memory one slot a cycle,
// giving one result per slot, min(RES_SIZE,32) in all. Results are shown for
// a single cycle under strobe_o and cannot be held off, so the receiver must
// take them as they come; the final result of an item carries last_o.
// ----------------------------------------------------------------------------
module lsh_bucket_reservoir_sampler #(
  parameter int TABLES      = 4,
  parameter int BUCKET_BITS = 10,
  parameter int RES_SIZE    = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item side
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [lbrs_pkg::ActW-1:0]   action_i,
  input  logic [lbrs_pkg::TblW-1:0]   table_req_i,
  input  logic [lbrs_pkg::BktW-1:0]   bucket_i,
  input  logic [lbrs_pkg::IdW-1:0]    vector_id_i,
  input  logic [lbrs_pkg::RndW-1:0]   random_word_i,
  // result side
  output logic                        strobe_o,
  output logic [lbrs_pkg::SlotW-1:0]  slot_o,
  output logic [lbrs_pkg::IdW-1:0]    value_o,
  output logic                        stored_o,
  output logic                        bucket_empty_o,
  output logic                        last_o
);
  import lbrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing: clearing pass, count lookup, fill or remainder, slot walk
  lbrs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // memories, remainder unit and result registers
  lbrs_dp #(
    .TABLES      (TABLES),
    .BUCKET_BITS (BUCKET_BITS),
    .RES_SIZE    (RES_SIZE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .table_req_i    (table_req_i),
    .bucket_i       (bucket_i),
    .vector_id_i    (vector_id_i),
    .random_word_i  (random_word_i),
    .strobe_o       (strobe_o),
    .slot_o         (slot_o),
    .value_o        (value_o),
    .stored_o       (stored_o),
    .bucket_empty_o (bucket_empty_o),
    .last_o         (last_o)
  );

endmodule
